### hw/rtl/aob_pkg.sv
package aob_pkg;

	localparam int unsigned NUM_CH = 3;

	// full coverage value of an 8-bit alpha
	localparam logic [7:0] FULL_SCALE = 8'd255;

	// ceil(2^32 / 255): exact floor(x / 255) for every x below 2^24
	localparam logic [24:0] RECIP_255 = 25'd16843010;

	typedef struct packed {
		logic [15:0] rem;
		logic [1:0]  q;
	} div2_t;

	// floor(x / 255) by reciprocal multiply, truncated to 16 bits; result below 2^16 for x below 255 * 2^16
	function automatic logic [15:0] div255(input logic [23:0] x);
		logic [48:0] prod;
		prod = 49'(x) * 49'(RECIP_255);
		return prod[47:32];
	endfunction

	// two restoring division steps, quotient bits lo+1 and lo
	function automatic div2_t div_step2(input logic [15:0] rem, input logic [7:0] den,
		input logic [2:0] lo);
		div2_t       r;
		logic [15:0] d;
		r.rem = rem;
		r.q   = 2'b00;
		d = 16'(den) << (lo + 3'd1);
		if (r.rem >= d) begin
			r.rem  = r.rem - d;
			r.q[1] = 1'b1;
		end
		d = 16'(den) << lo;
		if (r.rem >= d) begin
			r.rem  = r.rem - d;
			r.q[0] = 1'b1;
		end
		return r;
	endfunction

endpackage

### hw/rtl/aob_in_if.sv
interface aob_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] dest_red;
	logic [7:0] dest_green;
	logic [7:0] dest_blue;
	logic [7:0] dest_alpha;
	logic [7:0] src_red;
	logic [7:0] src_green;
	logic [7:0] src_blue;
	logic [7:0] src_alpha;

	modport source (
		output valid, dest_red, dest_green, dest_blue, dest_alpha,
		output src_red, src_green, src_blue, src_alpha,
		input  ready
	);

	modport sink (
		input  valid, dest_red, dest_green, dest_blue, dest_alpha,
		input  src_red, src_green, src_blue, src_alpha,
		output ready
	);
endinterface

### hw/rtl/aob_out_if.sv
interface aob_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;

	modport source (
		output valid, out_red, out_green, out_blue, out_alpha,
		input  ready
	);

	modport sink (
		input  valid, out_red, out_green, out_blue, out_alpha,
		output ready
	);
endinterface

### hw/rtl/alpha_over_blend_top.sv
// Source-over-destination compositing of straight-alpha RGBA8888 pixels.
//
// pixel: one beat carries a destination pixel and a source pixel.
// blend: one beat carries the composite color and its alpha.
// Both channels use valid/ready; a beat moves when both are high.
//
// The pipeline has eight register stages: two multiply stages, one
// divide-by-255 stage, four stages of the per-channel restoring divider
// (two quotient bits each, the first also checks saturation) and the
// output register. A new pixel is taken every cycle unless all stages are
// full and blend.ready is low; without such a stall, throughput is one pixel per clock.
//
// Each stage holds its beat until the next stage can take it, so empty
// stages close up while blend.ready is low and pixel.ready stays high
// until all eight stages are full. Nothing is dropped or repeated.
// Channels whose quotient exceeds 255 give 255; when both alphas are
// zero the result is all zeros.
// Reset clears all stage valid bits; blend.valid is low after reset.
module alpha_over_blend_top (
	input  logic           clk,
	input  logic           arst_n,
	aob_in_if.sink         pixel,
	aob_out_if.source      blend
);
	import aob_pkg::*;

	// stage valid bits and advance enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic en1, en2, en3, en4, en5, en6, en7, en8;

	// stage 1: products
	logic [15:0] ia_da_s1;
	logic [15:0] sa_sc_s1 [NUM_CH];
	logic [7:0]  dc_s1    [NUM_CH];
	logic [7:0]  sa_s1;

	// stage 2: output alpha and destination terms
	logic [7:0]  oa_s2;
	logic [23:0] t_s2     [NUM_CH];
	logic [15:0] sa_sc_s2 [NUM_CH];

	// stage 3: numerators
	logic [7:0]  oa_s3;
	logic [16:0] num_s3 [NUM_CH];

	// divider stages
	logic [7:0]  oa_s4, oa_s5, oa_s6, oa_s7;
	logic        zero_s4, zero_s5, zero_s6, zero_s7;
	logic [NUM_CH-1:0] sat_s4, sat_s5, sat_s6, sat_s7;
	logic [15:0] rem_s4 [NUM_CH];
	logic [15:0] rem_s5 [NUM_CH];
	logic [15:0] rem_s6 [NUM_CH];
	logic [15:0] rem_s7 [NUM_CH];
	logic [7:0]  q_s4   [NUM_CH];
	logic [7:0]  q_s5   [NUM_CH];
	logic [7:0]  q_s6   [NUM_CH];
	logic [7:0]  q_s7   [NUM_CH];

	// output stage
	logic [7:0] ch_s8 [NUM_CH];
	logic [7:0] oa_s8;

	logic [7:0] src_c [NUM_CH];
	logic [7:0] dst_c [NUM_CH];
	div2_t      step4 [NUM_CH];
	div2_t      step5 [NUM_CH];
	div2_t      step6 [NUM_CH];
	div2_t      step7 [NUM_CH];

	assign src_c[0] = pixel.src_red;
	assign src_c[1] = pixel.src_green;
	assign src_c[2] = pixel.src_blue;
	assign dst_c[0] = pixel.dest_red;
	assign dst_c[1] = pixel.dest_green;
	assign dst_c[2] = pixel.dest_blue;

	// a stage advances when empty or when the next one advances
	assign en8 = !vld_s8 || blend.ready;
	assign en7 = !vld_s7 || en8;
	assign en6 = !vld_s6 || en7;
	assign en5 = !vld_s5 || en6;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;

	assign pixel.ready = en1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= pixel.valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
			if (en6) vld_s6 <= vld_s5;
			if (en7) vld_s7 <= vld_s6;
			if (en8) vld_s8 <= vld_s7;
		end
	end

	// divider steps
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			step4[c] = div_step2(num_s3[c][15:0], oa_s3, 3'd6);
			step5[c] = div_step2(rem_s4[c], oa_s4, 3'd4);
			step6[c] = div_step2(rem_s5[c], oa_s5, 3'd2);
			step7[c] = div_step2(rem_s6[c], oa_s6, 3'd0);
		end
	end

	// stage 1: transparency of source times destination alpha, source terms
	always_ff @(posedge clk) begin
		if (en1) begin
			ia_da_s1 <= 16'(FULL_SCALE - pixel.src_alpha) * 16'(pixel.dest_alpha);
			sa_s1    <= pixel.src_alpha;
			for (int c = 0; c < NUM_CH; c++) begin
				sa_sc_s1[c] <= 16'(pixel.src_alpha) * 16'(src_c[c]);
				dc_s1[c]    <= dst_c[c];
			end
		end
	end

	// stage 2: output alpha, destination color terms
	always_ff @(posedge clk) begin
		if (en2) begin
			oa_s2 <= sa_s1 + 8'(div255(24'(ia_da_s1)));
			for (int c = 0; c < NUM_CH; c++) begin
				t_s2[c]     <= 24'(ia_da_s1) * 24'(dc_s1[c]);
				sa_sc_s2[c] <= sa_sc_s1[c];
			end
		end
	end

	// stage 3: channel numerators
	always_ff @(posedge clk) begin
		if (en3) begin
			oa_s3 <= oa_s2;
			for (int c = 0; c < NUM_CH; c++) begin
				num_s3[c] <= 17'(sa_sc_s2[c]) + 17'(div255(t_s2[c]));
			end
		end
	end

	// stage 4: saturation check and quotient bits 7..6
	always_ff @(posedge clk) begin
		if (en4) begin
			oa_s4   <= oa_s3;
			zero_s4 <= (oa_s3 == 8'd0);
			for (int c = 0; c < NUM_CH; c++) begin
				sat_s4[c] <= num_s3[c] >= {1'b0, oa_s3, 8'd0};
				rem_s4[c] <= step4[c].rem;
				q_s4[c]   <= {step4[c].q, 6'd0};
			end
		end
	end

	// stage 5: quotient bits 5..4
	always_ff @(posedge clk) begin
		if (en5) begin
			oa_s5   <= oa_s4;
			zero_s5 <= zero_s4;
			sat_s5  <= sat_s4;
			for (int c = 0; c < NUM_CH; c++) begin
				rem_s5[c] <= step5[c].rem;
				q_s5[c]   <= {q_s4[c][7:6], step5[c].q, 4'd0};
			end
		end
	end

	// stage 6: quotient bits 3..2
	always_ff @(posedge clk) begin
		if (en6) begin
			oa_s6   <= oa_s5;
			zero_s6 <= zero_s5;
			sat_s6  <= sat_s5;
			for (int c = 0; c < NUM_CH; c++) begin
				rem_s6[c] <= step6[c].rem;
				q_s6[c]   <= {q_s5[c][7:4], step6[c].q, 2'd0};
			end
		end
	end

	// stage 7: quotient bits 1..0
	always_ff @(posedge clk) begin
		if (en7) begin
			oa_s7   <= oa_s6;
			zero_s7 <= zero_s6;
			sat_s7  <= sat_s6;
			for (int c = 0; c < NUM_CH; c++) begin
				rem_s7[c] <= step7[c].rem;
				q_s7[c]   <= {q_s6[c][7:2], step7[c].q};
			end
		end
	end

	// stage 8: zero alpha and saturation override
	always_ff @(posedge clk) begin
		if (en8) begin
			oa_s8 <= oa_s7;
			for (int c = 0; c < NUM_CH; c++) begin
				if (zero_s7) begin
					ch_s8[c] <= 8'd0;
				end else if (sat_s7[c]) begin
					ch_s8[c] <= FULL_SCALE;
				end else begin
					ch_s8[c] <= q_s7[c];
				end
			end
		end
	end

	assign blend.valid     = vld_s8;
	assign blend.out_red   = ch_s8[0];
	assign blend.out_green = ch_s8[1];
	assign blend.out_blue  = ch_s8[2];
	assign blend.out_alpha = oa_s8;

	// zero alpha beat carries no color
	a_zero_alpha_black: assert property (@(posedge clk) disable iff (!arst_n)
		blend.valid && blend.out_alpha == 8'd0 |->
		blend.out_red == 8'd0 && blend.out_green == 8'd0 && blend.out_blue == 8'd0)
		else $error("nonzero color with zero output alpha");

	// finished division leaves a remainder below the divisor
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 && !zero_s7 && !sat_s7[0] |-> rem_s7[0] < 16'(oa_s7))
		else $error("divider remainder out of range");

	// pixel stalls only with every stage occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel.ready |->
		vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6 && vld_s7 && vld_s8)
		else $error("input stalled with an empty stage");

	// output alpha never falls below the source alpha it was built from
	a_alpha_cover: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && en2 |=> vld_s2 && oa_s2 >= $past(sa_s1))
		else $error("output alpha below source alpha");

endmodule

### test/alpha_over_blend_top_test.sv
`timescale 1ns / 1ps

module alpha_over_blend_top_test;

	import aob_pkg::FULL_SCALE;

	localparam int unsigned FULL       = FULL_SCALE;
	localparam int unsigned STALL_MAX  = 2000;
	localparam int unsigned TAIL_WAIT  = 40;
	localparam int unsigned SHOW_MAX   = 10;
	localparam int unsigned PHASE_ITEMS = 280;

	typedef enum logic [1:0] {
		PH_RECV_SLOW,
		PH_SEND_SLOW,
		PH_FULL_RATE
	} phase_t;

	typedef struct packed {
		logic [7:0] dest_red;
		logic [7:0] dest_green;
		logic [7:0] dest_blue;
		logic [7:0] dest_alpha;
		logic [7:0] src_red;
		logic [7:0] src_green;
		logic [7:0] src_blue;
		logic [7:0] src_alpha;
	} pixel_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
	} blend_t;

	typedef struct packed {
		pixel_t pix;
		phase_t phase;
		logic   drain_first;
	} pixel_job_t;

	logic clk;
	logic arst_n;

	aob_in_if  pixel_bus ();
	aob_out_if blend_bus ();

	alpha_over_blend_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel_bus),
		.blend  (blend_bus)
	);

	pixel_job_t  pixel_jobs[$];
	blend_t      expected_blends[$];
	phase_t      cur_phase;
	int unsigned pixels_in;
	int unsigned blends_out;
	int unsigned stall_cycles;
	int unsigned mismatch_count = 0;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// one color channel of the over composite, saturated
	function automatic logic [7:0] blend_channel(input logic [31:0] sa, input logic [7:0] sc,
		input logic [31:0] dst_weight, input logic [7:0] dc, input logic [31:0] cov);
		logic [31:0] num;
		logic [31:0] q;
		num = sa * sc + (dst_weight * dc) / FULL;
		q   = num / cov;
		return (q > FULL) ? 8'(FULL) : q[7:0];
	endfunction

	function automatic blend_t predict_blend(input pixel_t p);
		logic [31:0] sa;
		logic [31:0] dst_weight;
		logic [31:0] cov;
		blend_t      b;
		sa         = p.src_alpha;
		dst_weight = (FULL - sa) * p.dest_alpha;
		cov        = sa + dst_weight / FULL;
		b          = '0;
		// both alphas zero gives an all-zero pixel
		if (cov != 0) begin
			b.out_red   = blend_channel(sa, p.src_red, dst_weight, p.dest_red, cov);
			b.out_green = blend_channel(sa, p.src_green, dst_weight, p.dest_green, cov);
			b.out_blue  = blend_channel(sa, p.src_blue, dst_weight, p.dest_blue, cov);
			b.out_alpha = cov[7:0];
		end
		return b;
	endfunction

	function automatic int unsigned send_idle_pct(input phase_t ph);
		case (ph)
			PH_RECV_SLOW: return 6;
			PH_SEND_SLOW: return 59;
			default:      return 0;
		endcase
	endfunction

	function automatic int unsigned recv_idle_pct(input phase_t ph);
		case (ph)
			PH_RECV_SLOW: return 59;
			PH_SEND_SLOW: return 6;
			default:      return 0;
		endcase
	endfunction

	function automatic pixel_t mk_pixel(input logic [7:0] dr, dg, db, da, sr, sg, sb, sa);
		pixel_t p;
		p.dest_red   = dr;
		p.dest_green = dg;
		p.dest_blue  = db;
		p.dest_alpha = da;
		p.src_red    = sr;
		p.src_green  = sg;
		p.src_blue   = sb;
		p.src_alpha  = sa;
		return p;
	endfunction

	// alpha biased toward the ends of the range
	function automatic logic [7:0] rand_alpha();
		case ($urandom_range(7))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'($urandom_range(3));
			3:       return 8'($urandom_range(255, 252));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// color biased toward full and zero
	function automatic logic [7:0] rand_color();
		case ($urandom_range(7))
			0:       return 8'd255;
			1:       return 8'd0;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic pixel_t rand_pixel();
		return mk_pixel(rand_color(), rand_color(), rand_color(), rand_alpha(),
			rand_color(), rand_color(), rand_color(), rand_alpha());
	endfunction

	task automatic queue_pixel(input pixel_t p, input phase_t ph, input logic drain);
		pixel_job_t j;
		j.pix         = p;
		j.phase       = ph;
		j.drain_first = drain;
		pixel_jobs.push_back(j);
	endtask

	task automatic note_mismatch(input blend_t exp_b, input blend_t got_b);
		mismatch_count++;
		if (mismatch_count <= SHOW_MAX) begin
			$display("mismatch at %0t: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
				$realtime, exp_b.out_red, exp_b.out_green, exp_b.out_blue, exp_b.out_alpha,
				got_b.out_red, got_b.out_green, got_b.out_blue, got_b.out_alpha);
		end
	endtask

	// pixel driver, holds each beat until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bus.valid      <= 1'b0;
			pixel_bus.dest_red   <= '0;
			pixel_bus.dest_green <= '0;
			pixel_bus.dest_blue  <= '0;
			pixel_bus.dest_alpha <= '0;
			pixel_bus.src_red    <= '0;
			pixel_bus.src_green  <= '0;
			pixel_bus.src_blue   <= '0;
			pixel_bus.src_alpha  <= '0;
			cur_phase            <= PH_RECV_SLOW;
		end else if (!pixel_bus.valid || pixel_bus.ready) begin
			if (pixel_jobs.size() > 0 &&
				!(pixel_jobs[0].drain_first && (pixel_bus.valid || pixels_in != blends_out)) &&
				$urandom_range(99) >= send_idle_pct(pixel_jobs[0].phase)) begin
				pixel_bus.valid      <= 1'b1;
				pixel_bus.dest_red   <= pixel_jobs[0].pix.dest_red;
				pixel_bus.dest_green <= pixel_jobs[0].pix.dest_green;
				pixel_bus.dest_blue  <= pixel_jobs[0].pix.dest_blue;
				pixel_bus.dest_alpha <= pixel_jobs[0].pix.dest_alpha;
				pixel_bus.src_red    <= pixel_jobs[0].pix.src_red;
				pixel_bus.src_green  <= pixel_jobs[0].pix.src_green;
				pixel_bus.src_blue   <= pixel_jobs[0].pix.src_blue;
				pixel_bus.src_alpha  <= pixel_jobs[0].pix.src_alpha;
				cur_phase            <= pixel_jobs[0].phase;
				pixel_jobs.pop_front();
			end else begin
				pixel_bus.valid <= 1'b0;
			end
		end
	end

	// blend receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_bus.ready <= 1'b0;
		end else begin
			blend_bus.ready <= ($urandom_range(99) >= recv_idle_pct(cur_phase));
		end
	end

	// monitor: predict on pixel beats, check blend beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_in    <= 0;
			blends_out   <= 0;
			stall_cycles <= 0;
		end else begin
			if (pixel_bus.valid && pixel_bus.ready) begin
				expected_blends.push_back(predict_blend(mk_pixel(
					pixel_bus.dest_red, pixel_bus.dest_green, pixel_bus.dest_blue,
					pixel_bus.dest_alpha, pixel_bus.src_red, pixel_bus.src_green,
					pixel_bus.src_blue, pixel_bus.src_alpha)));
				pixels_in <= pixels_in + 1;
			end
			if (blend_bus.valid && blend_bus.ready) begin
				blend_t got_b;
				got_b.out_red   = blend_bus.out_red;
				got_b.out_green = blend_bus.out_green;
				got_b.out_blue  = blend_bus.out_blue;
				got_b.out_alpha = blend_bus.out_alpha;
				if (expected_blends.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= SHOW_MAX)
						$display("unexpected blend beat at %0t: r=%0d g=%0d b=%0d a=%0d",
							$realtime, got_b.out_red, got_b.out_green, got_b.out_blue,
							got_b.out_alpha);
				end else begin
					if (got_b !== expected_blends[0])
						note_mismatch(expected_blends[0], got_b);
					expected_blends.pop_front();
				end
				blends_out <= blends_out + 1;
			end
			// watchdog on beats in either direction
			if ((pixel_bus.valid && pixel_bus.ready) || (blend_bus.valid && blend_bus.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;

		// directed pixels: extremes, zero alpha, opaque, transparent, overflow
		queue_pixel(mk_pixel(0, 0, 0, 0, 0, 0, 0, 0), PH_RECV_SLOW, 1'b0);
		queue_pixel(mk_pixel(255, 255, 255, 255, 255, 255, 255, 255), PH_RECV_SLOW, 1'b0);
		queue_pixel(mk_pixel(255, 255, 255, 0, 255, 255, 255, 0), PH_RECV_SLOW, 1'b0);
		queue_pixel(mk_pixel(8'hAA, 8'h55, 8'hFF, 0, 8'h55, 8'hAA, 8'h01, 0), PH_RECV_SLOW, 1'b0);
		queue_pixel(mk_pixel(10, 20, 30, 255, 200, 100, 50, 255), PH_RECV_SLOW, 1'b0);
		queue_pixel(mk_pixel(200, 100, 50, 255, 1, 2, 3, 0), PH_RECV_SLOW, 1'b0);
		queue_pixel(mk_pixel(90, 180, 255, 128, 7, 7, 7, 0), PH_RECV_SLOW, 1'b0);
		queue_pixel(mk_pixel(255, 255, 255, 1, 255, 255, 255, 1), PH_RECV_SLOW, 1'b0);
		queue_pixel(mk_pixel(255, 255, 255, 2, 255, 255, 255, 3), PH_RECV_SLOW, 1'b0);
		queue_pixel(mk_pixel(255, 0, 128, 128, 0, 255, 128, 128), PH_RECV_SLOW, 1'b0);
		queue_pixel(mk_pixel(255, 255, 255, 0, 255, 0, 128, 1), PH_RECV_SLOW, 1'b0);
		queue_pixel(mk_pixel(0, 0, 0, 255, 255, 255, 255, 254), PH_RECV_SLOW, 1'b0);
		queue_pixel(mk_pixel(255, 128, 1, 1, 0, 0, 0, 0), PH_RECV_SLOW, 1'b0);
		queue_pixel(mk_pixel(8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'h55, 8'h55, 8'h55, 8'h55),
			PH_RECV_SLOW, 1'b0);
		queue_pixel(mk_pixel(8'h55, 8'h55, 8'h55, 8'h55, 8'hAA, 8'hAA, 8'hAA, 8'hAA),
			PH_RECV_SLOW, 1'b0);
		queue_pixel(mk_pixel(8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80),
			PH_RECV_SLOW, 1'b0);
		queue_pixel(mk_pixel(8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01),
			PH_RECV_SLOW, 1'b0);
		queue_pixel(mk_pixel(8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F),
			PH_RECV_SLOW, 1'b0);
		queue_pixel(mk_pixel(255, 255, 255, 255, 0, 0, 0, 1), PH_RECV_SLOW, 1'b0);
		queue_pixel(mk_pixel(0, 0, 0, 1, 255, 255, 255, 255), PH_RECV_SLOW, 1'b0);

		// random pixels, each phase starts from an empty pipeline
		for (int i = 0; i < PHASE_ITEMS; i++)
			queue_pixel(rand_pixel(), PH_RECV_SLOW, i == 0);
		for (int i = 0; i < PHASE_ITEMS; i++)
			queue_pixel(rand_pixel(), PH_SEND_SLOW, i == 0);
		for (int i = 0; i < PHASE_ITEMS; i++)
			queue_pixel(rand_pixel(), PH_FULL_RATE, i == 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// wait for all pixels taken and all blends back
		@(negedge clk);
		while (!(pixel_jobs.size() == 0 && !pixel_bus.valid && pixels_in == blends_out) &&
			stall_cycles < STALL_MAX)
			@(negedge clk);

		if (stall_cycles >= STALL_MAX) begin
			$display("FAILURE");
		end else begin
			repeat (TAIL_WAIT) @(negedge clk);
			// predictions never matched by a blend beat also fail
			if (mismatch_count + expected_blends.size() == 0) begin
				$display("SUCCESS");
			end else begin
				$display("FAILURE");
			end
		end
		$finish;
	end

endmodule
